// ===== src/assert_macros.svh =====
// Assertion macros shared by the scanner modules.
// Included by every module that checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ETKS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("etks assertion failed");
// Expression must never be true outside reset.
`define ETKS_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("etks forbidden condition");
`else
`define ETKS_ASSERT(label, clk, rst, prop)
`define ETKS_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== src/etks_pkg.sv =====
// Types, codes and keyword tables for the expression token scanner.
// Used by etks_front, etks_queue, etks_back and the top level; no dependencies.
package etks_pkg;

  localparam int NUM_KEYS = 17;

  typedef logic [NUM_KEYS-1:0] key_mask_t;

  // Token kinds
  localparam logic [4:0] KIND_END   = 5'd0;
  localparam logic [4:0] KIND_NUM   = 5'd1;
  localparam logic [4:0] KIND_IDENT = 5'd2;
  localparam logic [4:0] KIND_PLUS  = 5'd9;
  localparam logic [4:0] KIND_MINUS = 5'd10;
  localparam logic [4:0] KIND_STAR  = 5'd11;
  localparam logic [4:0] KIND_SLASH = 5'd12;
  localparam logic [4:0] KIND_LPAR  = 5'd13;
  localparam logic [4:0] KIND_RPAR  = 5'd14;
  localparam logic [4:0] KIND_COMMA = 5'd15;

  // Result item kinds
  localparam logic ITEM_ECHO = 1'b0;
  localparam logic ITEM_TOKEN = 1'b1;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam logic [3:0] LEN_ONE = 4'd1;
  localparam logic [3:0] LEN_SAT = 4'd9;

  // Keyword text, right-aligned: the last character sits in the low byte.
  localparam logic [63:0] KEY_TEXT [NUM_KEYS] = '{
    64'("Max"), 64'("Min"), 64'("Pow"), 64'("Log"), 64'("Ceiling"),
    64'("Rational"), 64'("Abs"), 64'("ExpectEq"), 64'("ExpectNe"),
    64'("ExpectLe"), 64'("ExpectLt"), 64'("True"), 64'("False"),
    64'("Floor"), 64'("Mod"), 64'("LogicAnd"), 64'("LogicOr")
  };
  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd8, 4'd3, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd4, 4'd5, 4'd5, 4'd3, 4'd8, 4'd7
  };
  localparam logic [4:0] KEY_KIND [NUM_KEYS] = '{
    5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20,
    5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26
  };

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_HALT  = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic       item_kind;
    logic [4:0] token_kind;
    logic [7:0] text_char;
    logic       scan_error;
  } result_t;

  // Everything one input item causes: one or two results.
  typedef struct packed {
    result_t res0;
    result_t res1;
    logic    two;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_req_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Returns KIND_END for anything that is not a one-character operator.
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      CH_PLUS:  k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_STAR:  k = KIND_STAR;
      CH_SLASH: k = KIND_SLASH;
      CH_LPAR:  k = KIND_LPAR;
      CH_RPAR:  k = KIND_RPAR;
      CH_COMMA: k = KIND_COMMA;
      default:  k = KIND_END;
    endcase
    return k;
  endfunction

  // Keywords whose character at position pos equals c.
  function automatic key_mask_t narrow_mask(input logic [3:0] pos, input logic [7:0] c);
    key_mask_t m;
    logic [3:0] off;
    m = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      off = KEY_LEN[k] - pos - LEN_ONE;
      if ((pos < KEY_LEN[k]) && (KEY_TEXT[k][8*off[2:0] +: 8] == c)) begin
        m[k] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic [4:0] ident_kind(input key_mask_t cand, input logic [3:0] len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (cand[k] && (KEY_LEN[k] == len)) begin
        kind = KEY_KIND[k];
      end
    end
    return kind;
  endfunction

  function automatic result_t make_res(input logic ik, input logic [4:0] kind,
                                       input logic [7:0] ch, input logic err);
    result_t r;
    r.item_kind  = ik;
    r.token_kind = kind;
    r.text_char  = ch;
    r.scan_error = err;
    return r;
  endfunction

endpackage

// ===== src/expression_token_scanner.sv =====
// Top level of the expression token scanner: front end, result queue, back end.
// Depends on etks_pkg, etks_front, etks_queue and etks_back.
//
//   channel  | handshake         | payload
//   ---------+-------------------+----------------------------------------------
//   input    | in_valid/in_stall | char_code, end_of_input, first_of_expression
//   result   | out_valid/out_stall | item_kind, token_kind, text_char,
//            |                   | scan_error, last_of_run
//
// One character per cycle is accepted while the queue is not full; results
// leave one per cycle while out_stall is low, so a character that closes a token
// and starts another yields two results, queued and then registered for output.
// Reset returns scanning to between-tokens and empties the queue.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full; out_stall
// holds the output register and backs up into the queue.

module expression_token_scanner #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  input  logic       first_of_expression,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       item_kind,
  output logic [4:0] token_kind,
  output logic [7:0] text_char,
  output logic       scan_error,
  output logic       last_of_run
);

  etks_pkg::push_req_t push;
  etks_pkg::entry_t    head;
  logic                q_full, q_empty, pop;

  etks_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .char_code           (char_code),
    .end_of_input        (end_of_input),
    .first_of_expression (first_of_expression),
    .q_full              (q_full),
    .push                (push)
  );

  etks_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .head  (head)
  );

  etks_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .item_kind   (item_kind),
    .token_kind  (token_kind),
    .text_char   (text_char),
    .scan_error  (scan_error),
    .last_of_run (last_of_run)
  );

endmodule

// ===== src/etks_front.sv =====
// Front end: accepts characters, tracks scan mode and keyword candidates,
// and builds the one or two results of each character. Uses etks_pkg.
`include "assert_macros.svh"

module etks_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          char_code,
  input  logic                end_of_input,
  input  logic                first_of_expression,
  input  logic                q_full,
  output etks_pkg::push_req_t push
);

  etks_pkg::scan_mode_t mode, mode_next, mode_eff, idle_mode;
  etks_pkg::key_mask_t  cand, cand_next, mask;
  logic [3:0]           len, len_next, pos;
  logic [7:0]           c;
  logic                 accept;
  logic                 idle_push, start_ident, ident_char;
  etks_pkg::result_t    idle_res;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    c = end_of_input ? etks_pkg::CH_NUL : char_code;
    mode_eff = first_of_expression ? etks_pkg::MODE_IDLE : mode;
    ident_char = etks_pkg::is_letter(c) || etks_pkg::is_digit(c) ||
                 (c == etks_pkg::CH_COLON) || (c == etks_pkg::CH_UNDERSCORE);

    // What the character does between tokens
    idle_push   = 1'b1;
    idle_mode   = etks_pkg::MODE_IDLE;
    start_ident = 1'b0;
    idle_res    = etks_pkg::make_res(etks_pkg::ITEM_TOKEN, etks_pkg::KIND_END,
                                     etks_pkg::CH_NUL, 1'b0);
    if (c == etks_pkg::CH_NUL) begin
      idle_mode = etks_pkg::MODE_HALT;
    end else if (etks_pkg::is_space(c)) begin
      idle_push = 1'b0;
    end else if (etks_pkg::is_digit(c)) begin
      idle_mode = etks_pkg::MODE_NUM;
      idle_res  = etks_pkg::make_res(etks_pkg::ITEM_ECHO, etks_pkg::KIND_NUM, c, 1'b0);
    end else if (etks_pkg::is_letter(c)) begin
      idle_mode   = etks_pkg::MODE_IDENT;
      start_ident = 1'b1;
      idle_res    = etks_pkg::make_res(etks_pkg::ITEM_ECHO, etks_pkg::KIND_IDENT, c, 1'b0);
    end else if (etks_pkg::op_kind(c) != etks_pkg::KIND_END) begin
      idle_res = etks_pkg::make_res(etks_pkg::ITEM_TOKEN, etks_pkg::op_kind(c), c, 1'b0);
    end else begin
      idle_mode = etks_pkg::MODE_HALT;
      idle_res  = etks_pkg::make_res(etks_pkg::ITEM_TOKEN, etks_pkg::KIND_END,
                                     etks_pkg::CH_NUL, 1'b1);
    end

    // A new identifier matches from position zero
    pos  = (mode_eff == etks_pkg::MODE_IDENT) ? len : 4'd0;
    mask = etks_pkg::narrow_mask(pos, c);

    mode_next = mode;
    cand_next = cand;
    len_next  = len;
    push.valid = 1'b0;
    push.entry.res0 = idle_res;
    push.entry.res1 = idle_res;
    push.entry.two  = 1'b0;

    case (mode_eff)
      etks_pkg::MODE_NUM: begin
        push.valid = 1'b1;
        if (etks_pkg::is_digit(c) || (c == etks_pkg::CH_DOT)) begin
          mode_next = etks_pkg::MODE_NUM;
          push.entry.res0 = etks_pkg::make_res(etks_pkg::ITEM_ECHO, etks_pkg::KIND_NUM,
                                               c, 1'b0);
        end else begin
          mode_next = idle_mode;
          push.entry.res0 = etks_pkg::make_res(etks_pkg::ITEM_TOKEN, etks_pkg::KIND_NUM,
                                               etks_pkg::CH_NUL, 1'b0);
          push.entry.two = idle_push;
          if (start_ident) begin
            cand_next = mask;
            len_next  = etks_pkg::LEN_ONE;
          end
        end
      end
      etks_pkg::MODE_IDENT: begin
        push.valid = 1'b1;
        if (ident_char) begin
          mode_next = etks_pkg::MODE_IDENT;
          cand_next = cand & mask;
          len_next  = (len < etks_pkg::LEN_SAT) ? len + etks_pkg::LEN_ONE : len;
          push.entry.res0 = etks_pkg::make_res(etks_pkg::ITEM_ECHO, etks_pkg::KIND_IDENT,
                                               c, 1'b0);
        end else begin
          mode_next = idle_mode;
          push.entry.res0 = etks_pkg::make_res(etks_pkg::ITEM_TOKEN,
                                               etks_pkg::ident_kind(cand, len),
                                               etks_pkg::CH_NUL, 1'b0);
          push.entry.two = idle_push;
        end
      end
      etks_pkg::MODE_HALT: begin
        mode_next = etks_pkg::MODE_HALT;
      end
      default: begin
        mode_next  = idle_mode;
        push.valid = idle_push;
        if (start_ident) begin
          cand_next = mask;
          len_next  = etks_pkg::LEN_ONE;
        end
      end
    endcase
    push.valid = push.valid && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= etks_pkg::MODE_IDLE;
      len  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      len  <= len_next;
    end
  end

  // Candidates are always written when an identifier starts
  always_ff @(posedge clk) begin
    if (accept) begin
      cand <= cand_next;
    end
  end

  `ETKS_ASSERT(a_halt_silent, clk, rst, (mode == etks_pkg::MODE_HALT && in_valid && !first_of_expression) |-> !push.valid)
  `ETKS_ASSERT(a_pair_starts_token, clk, rst, (push.valid && push.entry.two) |-> (push.entry.res0.item_kind == etks_pkg::ITEM_TOKEN))
  `ETKS_NEVER(a_len_range, clk, rst, len > etks_pkg::LEN_SAT)

endmodule

// ===== src/etks_queue.sv =====
// Short queue of per-character result entries between front and back end.
// Uses etks_pkg for the entry and request types.
`include "assert_macros.svh"

module etks_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  etks_pkg::push_req_t push,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output etks_pkg::entry_t    head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  etks_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  `ETKS_NEVER(a_push_when_full, clk, rst, push.valid && full)
  `ETKS_NEVER(a_count_range, clk, rst, count > CNT_W'(DEPTH))

endmodule

// ===== src/etks_back.sv =====
// Back end: drains queue entries into the registered result port, one result per
// cycle when not stalled, marking each character's last result. Uses etks_pkg.
`include "assert_macros.svh"

module etks_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  etks_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             item_kind,
  output logic [4:0]       token_kind,
  output logic [7:0]       text_char,
  output logic             scan_error,
  output logic             last_of_run
);

  logic              sub;   // 1 while the second result of the head entry is due
  logic              out_load, cur_last;
  etks_pkg::result_t cur;

  assign out_load = !out_valid || !out_stall;

  always_comb begin
    cur      = sub ? head.res1 : head.res0;
    cur_last = !head.two || sub;
    pop      = out_load && !empty && cur_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (out_load) begin
      out_valid <= !empty;
      if (!empty) begin
        sub <= !cur_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && !empty) begin
      item_kind   <= cur.item_kind;
      token_kind  <= cur.token_kind;
      text_char   <= cur.text_char;
      scan_error  <= cur.scan_error;
      last_of_run <= cur_last;
    end
  end

  `ETKS_NEVER(a_second_without_entry, clk, rst, sub && empty)

endmodule
